// File: design/hsir_pkg.sv
// Shared types, constants and register map of the humidity sensor I2C reader.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hsir_pkg;

  // Widths of the stream fields and of the configuration registers
  localparam int unsigned READ_BYTES_DEF = 6;
  localparam int unsigned ADDR_W         = 7;
  localparam int unsigned TICK_W         = 20;
  localparam int unsigned RAW_W          = 20;
  localparam int unsigned HUM_W          = 14;
  localparam int unsigned TEMP_W         = 15;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 20;
  localparam int unsigned IN_TDATA_W     = 8;
  localparam int unsigned OUT_FIELDS_W   = 5 + 2 * RAW_W + HUM_W + TEMP_W;
  localparam int unsigned OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W      = OUT_TDATA_W - OUT_FIELDS_W;

  // Command codes carried in the input word
  localparam logic [1:0] CMD_INIT    = 2'd1;
  localparam logic [1:0] CMD_MEASURE = 2'd2;

  // Bytes sent after the address byte
  localparam logic [7:0] INIT_BYTE_0 = 8'hBE;
  localparam logic [7:0] INIT_BYTE_1 = 8'h08;
  localparam logic [7:0] MEAS_BYTE_0 = 8'hAC;
  localparam logic [7:0] MEAS_BYTE_1 = 8'h33;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;

  // Status byte: sensor still busy
  localparam int unsigned STATUS_BUSY_BIT = 7;

  // Fixed-point scaling to hundredths
  localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
  localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEV_ADDR    = 2'd0,
    REG_POWER_UP    = 2'd1,
    REG_INIT_SETTLE = 2'd2,
    REG_MEAS_WAIT   = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_PWR_WAIT    = 4'd1,
    PH_START_A     = 4'd2,
    PH_START_B     = 4'd3,
    PH_WBIT_LO     = 4'd4,
    PH_WBIT_HI     = 4'd5,
    PH_RBIT_LO     = 4'd6,
    PH_RBIT_HI     = 4'd7,
    PH_STOP_A      = 4'd8,
    PH_STOP_B      = 4'd9,
    PH_STOP_C      = 4'd10,
    PH_MEAS_WAIT   = 4'd11,
    PH_SETTLE_WAIT = 4'd12,
    PH_DONE        = 4'd13
  } phase_e;

  typedef struct packed {
    logic [1:0] command;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dev_addr;
    logic [TICK_W-1:0] power_up;
    logic [TICK_W-1:0] init_settle;
    logic [TICK_W-1:0] meas_wait;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    dev_addr:    7'h38,
    power_up:    20'd8000,
    init_settle: 20'd2000,
    meas_wait:   20'd16000
  };

  // Per-tick result of the sequencer
  typedef struct packed {
    logic             scl_pull_low;
    logic             sda_pull_low;
    logic             busy;
    logic             done;
    logic             success;
    logic [RAW_W-1:0] hum_raw;
    logic [RAW_W-1:0] temp_raw;
  } step_t;

endpackage

// File: design/hsir_cfg.sv
// Configuration register file of the humidity sensor I2C reader.
// Depends on hsir_pkg.
`timescale 1ns / 1ps

module hsir_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hsir_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hsir_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output hsir_pkg::cfg_t                   cfg_o
);
  import hsir_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    unique case (reg_e'(cfg_index_i))
      REG_DEV_ADDR:    cfg_d.dev_addr    = cfg_data_i[ADDR_W-1:0];
      REG_POWER_UP:    cfg_d.power_up    = cfg_data_i[TICK_W-1:0];
      REG_INIT_SETTLE: cfg_d.init_settle = cfg_data_i[TICK_W-1:0];
      REG_MEAS_WAIT:   cfg_d.meas_wait   = cfg_data_i[TICK_W-1:0];
      default:         cfg_d = cfg_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/hsir_scale.sv
// Fixed-point conversion of raw humidity and temperature to hundredths.
// Depends on hsir_pkg.
`timescale 1ns / 1ps

module hsir_scale (
  input  logic [hsir_pkg::RAW_W-1:0]         hum_raw_i,
  input  logic [hsir_pkg::RAW_W-1:0]         temp_raw_i,
  output logic [hsir_pkg::HUM_W-1:0]         humidity_centi_o,
  output logic signed [hsir_pkg::TEMP_W-1:0] temperature_centi_o
);
  import hsir_pkg::*;

  logic [RAW_W+HUM_W-1:0]  hum_prod;
  logic [RAW_W+TEMP_W-1:0] temp_prod;
  logic [TEMP_W-1:0]       temp_scaled;

  // raw * 10000 / 2^20, truncated
  assign hum_prod         = (RAW_W+HUM_W)'(hum_raw_i) * (RAW_W+HUM_W)'(HUM_SCALE);
  assign humidity_centi_o = hum_prod[RAW_W +: HUM_W];

  // raw * 20000 / 2^20 - 5000, two's complement
  assign temp_prod           = (RAW_W+TEMP_W)'(temp_raw_i) * (RAW_W+TEMP_W)'(TEMP_SCALE);
  assign temp_scaled         = temp_prod[RAW_W +: TEMP_W];
  assign temperature_centi_o = $signed(temp_scaled - TEMP_OFFSET);

endmodule

// File: design/hsir_seq.sv
// Tick sequencer: bit-banged I2C master, waits, read-back and unpacking.
// Depends on hsir_pkg.
`timescale 1ns / 1ps

module hsir_seq #(
  parameter int unsigned READ_BYTES = hsir_pkg::READ_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_en_i,
  input  hsir_pkg::item_t item_i,
  input  hsir_pkg::cfg_t  cfg_i,
  output hsir_pkg::step_t step_o
);
  import hsir_pkg::*;

  localparam int unsigned       BYTE_W     = $clog2(READ_BYTES);
  localparam logic [BYTE_W-1:0] LAST_RBYTE = BYTE_W'(READ_BYTES - 1);
  localparam logic [BYTE_W-1:0] LAST_WBYTE = BYTE_W'(3);
  localparam logic [3:0]        ACK_BIT    = 4'd8;

  phase_e            phase_q, phase_d;
  logic              act_q, act_d;      // 1: measure, 0: init
  logic              rd_q, rd_d;        // read transfer in progress
  logic              acks_q, acks_d;
  logic [TICK_W-1:0] cnt_q, cnt_d;
  logic [3:0]        bit_q, bit_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [7:0]        shift_q, shift_d;
  logic [RAW_W-1:0]  hum_q, hum_d;
  logic [RAW_W-1:0]  temp_q, temp_d;
  logic [7:0]        rxb_q [READ_BYTES];
  logic              rxb_we;

  // Resolved state for this tick (command start, zero-length waits)
  phase_e            ph_a, ph_x;
  logic              act_a, acks_a, rd_a, rd_x;
  logic [TICK_W-1:0] cnt_a, target;
  logic              wait_ph, wait_over;
  logic              wbit_sda, rbit_sda;
  logic [7:0]        next_tx;
  logic [RAW_W-1:0]  hum_dec, temp_dec;
  logic              status_ok;

  always_comb begin
    ph_a   = phase_q;
    act_a  = act_q;
    acks_a = acks_q;
    rd_a   = rd_q;
    cnt_a  = cnt_q;
    if (phase_q == PH_IDLE) begin
      if (item_i.command == CMD_INIT) begin
        ph_a   = PH_PWR_WAIT;
        act_a  = 1'b0;
        acks_a = 1'b1;
        rd_a   = 1'b0;
        cnt_a  = '0;
      end else if (item_i.command == CMD_MEASURE) begin
        ph_a   = PH_START_A;
        act_a  = 1'b1;
        acks_a = 1'b1;
        rd_a   = 1'b0;
      end
    end

    wait_ph = (ph_a == PH_PWR_WAIT) || (ph_a == PH_MEAS_WAIT) || (ph_a == PH_SETTLE_WAIT);
    if (ph_a == PH_PWR_WAIT) begin
      target = cfg_i.power_up;
    end else if (ph_a == PH_MEAS_WAIT) begin
      target = cfg_i.meas_wait;
    end else begin
      target = cfg_i.init_settle;
    end
    wait_over = wait_ph && !(cnt_a < target);

    ph_x = ph_a;
    rd_x = rd_a;
    if (wait_over) begin
      if (ph_a == PH_PWR_WAIT) begin
        ph_x = PH_START_A;
        rd_x = 1'b0;
      end else if (ph_a == PH_MEAS_WAIT) begin
        ph_x = PH_START_A;
        rd_x = 1'b1;
      end else begin
        ph_x = PH_DONE;
      end
    end
  end

  // Data bit driven during write and read bit pairs
  assign wbit_sda = (bit_q < ACK_BIT) ? ~shift_q[3'd7 - bit_q[2:0]] : 1'b0;
  assign rbit_sda = (bit_q >= ACK_BIT) && (byte_q != LAST_RBYTE);

  always_comb begin
    case (byte_q)
      BYTE_W'(0): next_tx = act_a ? MEAS_BYTE_0 : INIT_BYTE_0;
      BYTE_W'(1): next_tx = act_a ? MEAS_BYTE_1 : INIT_BYTE_1;
      default:    next_tx = ZERO_BYTE;
    endcase
  end

  // Status byte, then 20-bit humidity and 20-bit temperature
  assign hum_dec   = {rxb_q[1], rxb_q[2], rxb_q[3][7:4]};
  assign temp_dec  = {rxb_q[3][3:0], rxb_q[4], rxb_q[5]};
  assign status_ok = ~rxb_q[0][STATUS_BUSY_BIT];

  // Next state
  always_comb begin
    phase_d = ph_x;
    act_d   = act_a;
    rd_d    = rd_x;
    acks_d  = acks_a;
    cnt_d   = cnt_a;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    hum_d   = hum_q;
    temp_d  = temp_q;
    rxb_we  = 1'b0;
    unique case (ph_x)
      PH_IDLE: ;
      PH_PWR_WAIT, PH_MEAS_WAIT, PH_SETTLE_WAIT: begin
        cnt_d = cnt_a + TICK_W'(1);
      end
      PH_START_A: begin
        phase_d = PH_START_B;
        bit_d   = '0;
        byte_d  = '0;
        shift_d = {cfg_i.dev_addr, rd_x};
      end
      PH_START_B: phase_d = PH_WBIT_LO;
      PH_WBIT_LO: phase_d = PH_WBIT_HI;
      PH_WBIT_HI: begin
        if (bit_q < ACK_BIT) begin
          bit_d   = bit_q + 4'd1;
          phase_d = PH_WBIT_LO;
        end else begin
          if (item_i.sda_in) begin
            acks_d = 1'b0;
          end
          bit_d = '0;
          if (rd_x) begin
            byte_d  = '0;
            shift_d = '0;
            phase_d = PH_RBIT_LO;
          end else begin
            byte_d = byte_q + BYTE_W'(1);
            if (byte_q == LAST_WBYTE) begin
              phase_d = PH_STOP_A;
            end else begin
              shift_d = next_tx;
              phase_d = PH_WBIT_LO;
            end
          end
        end
      end
      PH_RBIT_LO: phase_d = PH_RBIT_HI;
      PH_RBIT_HI: begin
        if (bit_q < ACK_BIT) begin
          shift_d = {shift_q[6:0], item_i.sda_in};
          bit_d   = bit_q + 4'd1;
          phase_d = PH_RBIT_LO;
        end else begin
          rxb_we  = 1'b1;
          bit_d   = '0;
          shift_d = '0;
          byte_d  = byte_q + BYTE_W'(1);
          phase_d = (byte_q == LAST_RBYTE) ? PH_STOP_A : PH_RBIT_LO;
        end
      end
      PH_STOP_A: phase_d = PH_STOP_B;
      PH_STOP_B: phase_d = PH_STOP_C;
      PH_STOP_C: begin
        if (rd_x) begin
          acks_d = acks_a & status_ok;
          if (acks_a && status_ok) begin
            hum_d  = hum_dec;
            temp_d = temp_dec;
          end
          phase_d = PH_DONE;
        end else if (!act_a) begin
          cnt_d   = '0;
          phase_d = PH_SETTLE_WAIT;
        end else if (acks_a) begin
          cnt_d   = '0;
          phase_d = PH_MEAS_WAIT;
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_DONE: phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    step_o              = '0;
    step_o.busy         = 1'b1;
    step_o.hum_raw      = hum_d;
    step_o.temp_raw     = temp_d;
    unique case (ph_x)
      PH_IDLE: step_o.busy = 1'b0;
      PH_PWR_WAIT, PH_MEAS_WAIT, PH_SETTLE_WAIT, PH_START_A: ;
      PH_START_B: step_o.sda_pull_low = 1'b1;
      PH_WBIT_LO: begin
        step_o.scl_pull_low = 1'b1;
        step_o.sda_pull_low = wbit_sda;
      end
      PH_WBIT_HI: step_o.sda_pull_low = wbit_sda;
      PH_RBIT_LO: begin
        step_o.scl_pull_low = 1'b1;
        step_o.sda_pull_low = rbit_sda;
      end
      PH_RBIT_HI: step_o.sda_pull_low = rbit_sda;
      PH_STOP_A: begin
        step_o.scl_pull_low = 1'b1;
        step_o.sda_pull_low = 1'b1;
      end
      PH_STOP_B: step_o.sda_pull_low = 1'b1;
      PH_STOP_C: ;
      PH_DONE: begin
        step_o.done    = 1'b1;
        step_o.success = acks_a;
      end
      default: step_o.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      act_q   <= 1'b0;
      rd_q    <= 1'b0;
      acks_q  <= 1'b1;
      cnt_q   <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      hum_q   <= '0;
      temp_q  <= '0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      act_q   <= act_d;
      rd_q    <= rd_d;
      acks_q  <= acks_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      hum_q   <= hum_d;
      temp_q  <= temp_d;
    end
  end

  // Received bytes, no reset
  always_ff @(posedge clk_i) begin
    if (step_en_i && rxb_we) begin
      rxb_q[byte_q] <= shift_q;
    end
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && step_o.done) |=> (phase_q == PH_IDLE))
    else $error("sequencer did not return to idle after done");

  a_success_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_o.success |-> step_o.done)
    else $error("success flagged without done");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> ($stable(phase_q) && $stable(cnt_q) && $stable(shift_q)))
    else $error("sequencer state moved without a tick");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= ACK_BIT)
    else $error("bit counter past the ack bit");

  a_read_phase_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RBIT_LO || phase_q == PH_RBIT_HI) |-> rd_q)
    else $error("read bit phase outside a read transfer");

endmodule

// File: design/humidity_sensor_i2c_reader.sv
// Humidity sensor I2C reader. Each input word is one half-bit tick of the bus
// from an external prescaler, carrying a command (0 tick, 1 init, 2 measure;
// ignored while busy) and the sampled SDA level; each accepted word yields
// exactly one result word with the SCL/SDA pull-low controls, busy/done/success
// and the last good raw and scaled readings. Throughput is one word per clock
// while the receiver keeps m_axis_tready high: the sequencer advances once per
// word, as it moves from an input register into a result register, from which
// the result word is offered. Bus timing is set entirely by the tick rate;
// clock stretching is not supported.
// Configuration (address, power-up, settle and measure wait in ticks) may be
// written only while no command is running. Depends on hsir_pkg, hsir_cfg,
// hsir_seq and hsir_scale.
`timescale 1ns / 1ps

module humidity_sensor_i2c_reader #(
  parameter int unsigned READ_BYTES = hsir_pkg::READ_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: [1:0] command, [2] sda_in, [7:3] zero
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [hsir_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tdata: [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res,
  //        [4] success, [24:5] raw humidity, [44:25] raw temperature,
  //        [58:45] humidity_centi, [73:59] temperature_centi, [79:74] zero
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [hsir_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [hsir_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hsir_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import hsir_pkg::*;

  cfg_t                     cfg;
  step_t                    step;
  logic [HUM_W-1:0]         hum_centi;
  logic signed [TEMP_W-1:0] temp_centi;

  // Input register
  logic  in_valid_q, in_valid_d;
  item_t in_item_q;
  logic  in_accept;

  // Result register
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic advance;  // word moves from input register to result register

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q.command <= s_axis_tdata[1:0];
      in_item_q.sda_in  <= s_axis_tdata[2];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  hsir_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hsir_seq #(
    .READ_BYTES (READ_BYTES)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .step_o    (step)
  );

  hsir_scale u_scale (
    .hum_raw_i           (step.hum_raw),
    .temp_raw_i          (step.temp_raw),
    .humidity_centi_o    (hum_centi),
    .temperature_centi_o (temp_centi)
  );

  // Pack highest field first, scl_pull_low in bit 0
  assign out_data_d = {OUT_PAD_W'(0), temp_centi, hum_centi, step.temp_raw, step.hum_raw,
                       step.success, step.done, step.busy, step.sda_pull_low,
                       step.scl_pull_low};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled with empty input register");

  a_result_follows_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result word lost after advance");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !advance)
    else $error("pending result word overwritten");

endmodule

// File: sim/tb_humidity_sensor_i2c_reader.sv
// Self-checking testbench for humidity_sensor_i2c_reader: streams half-bit tick
// words, emulates the sensor on SDA and predicts every result word in order.
// Depends on hsir_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_humidity_sensor_i2c_reader;
  import hsir_pkg::*;

  localparam int unsigned RX_COUNT    = READ_BYTES_DEF;
  localparam int unsigned CLK_HALF    = 6;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_TICKS = 100;
  // no idling on either side inside this window of cycles
  localparam int unsigned QUIET_FROM  = 200;
  localparam int unsigned QUIET_TO    = 800;
  // receiver holds off once, no earlier than HOLD_AT; HOLD_LEN sets its length
  localparam int unsigned HOLD_AT     = 1000;
  localparam int unsigned HOLD_LEN    = 400;
  localparam logic [19:0] TICKS_MAX   = 20'hFFFFF;

  // command codes not named in the package
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {SENSOR_OK, SENSOR_NACK, SENSOR_BUSY, SENSOR_NOISE} sensor_mode_e;

  // result word layout, lowest field last
  typedef struct packed {
    logic [TEMP_W-1:0] temp_centi;
    logic [HUM_W-1:0]  hum_centi;
    logic [RAW_W-1:0]  temp_raw;
    logic [RAW_W-1:0]  hum_raw;
    logic              success;
    logic              done;
    logic              busy;
    logic              sda_low;
    logic              scl_low;
  } bus_word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  humidity_sensor_i2c_reader uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  logic [IN_TDATA_W-1:0] tick_queue[$];     // words waiting for the driver
  bus_word_t             expected_words[$]; // predicted result words, in order
  int unsigned           ticks_made = 0;
  int unsigned           words_seen = 0;
  int unsigned           mismatches = 0;
  int unsigned           cycle_cnt = 0;
  int unsigned           hold_left = 0;
  bit                    hold_done = 1'b0;
  bus_word_t             mon_got, mon_want;

  // ---------------------------------------------------------------------------
  // Predictor: own copy of configuration and sequencer state
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] cfg_addr   = 7'h38;
  logic [TICK_W-1:0] cfg_pwr    = 20'd8000;
  logic [TICK_W-1:0] cfg_settle = 20'd2000;
  logic [TICK_W-1:0] cfg_meas   = 20'd16000;

  phase_e            bus_phase    = PH_IDLE;
  logic              xfer_is_meas = 1'b0;
  logic [TICK_W-1:0] wait_ticks   = '0;
  logic [3:0]        bit_idx      = '0;
  logic [2:0]        byte_idx     = '0;
  logic [7:0]        shreg        = '0;
  logic [7:0]        rx_bytes [RX_COUNT];
  logic              acks_ok      = 1'b1;
  logic [RAW_W-1:0]  hum_store    = '0;
  logic [RAW_W-1:0]  temp_store   = '0;
  logic              reading_back = 1'b0;

  initial begin
    foreach (rx_bytes[i]) rx_bytes[i] = 8'h00;
  end

  // byte to shift out at position pos of the current write
  function automatic logic [7:0] out_byte(int unsigned pos);
    logic [7:0] a;
    a = {cfg_addr, 1'b0};
    if (reading_back) return a | 8'h01;
    case (pos)
      0: return a;
      1: return xfer_is_meas ? MEAS_BYTE_0 : INIT_BYTE_0;
      2: return xfer_is_meas ? MEAS_BYTE_1 : INIT_BYTE_1;
      default: return ZERO_BYTE;
    endcase
  endfunction

  function automatic void open_bus();
    byte_idx  = '0;
    bit_idx   = '0;
    shreg     = out_byte(0);
    bus_phase = PH_START_A;
  endfunction

  // unpack the reading; a busy status or any bad ack keeps the old stores
  function automatic void close_read();
    if (rx_bytes[0][STATUS_BUSY_BIT]) acks_ok = 1'b0;
    if (!acks_ok) return;
    hum_store  = {rx_bytes[1], rx_bytes[2], rx_bytes[3][7:4]};
    temp_store = {rx_bytes[3][3:0], rx_bytes[4], rx_bytes[5]};
  endfunction

  // one half-bit tick; zero-length waits fall through to the next phase
  function automatic bus_word_t advance_bus(logic [1:0] cmd, logic sda);
    bus_word_t         w;
    logic              scl_lo, sda_lo, busy, done, ok, hi;
    bit                consumed;
    int                guard, tc;
    logic [TICK_W-1:0] target;
    longint unsigned   prod;
    scl_lo   = 1'b0;
    sda_lo   = 1'b0;
    busy     = 1'b1;
    done     = 1'b0;
    ok       = 1'b0;
    consumed = 1'b0;
    for (guard = 0; guard < 8 && !consumed; guard++) begin
      case (bus_phase)
        PH_IDLE: begin
          if (cmd == CMD_INIT) begin
            xfer_is_meas = 1'b0;
            acks_ok      = 1'b1;
            reading_back = 1'b0;
            wait_ticks   = '0;
            bus_phase    = PH_PWR_WAIT;
          end else if (cmd == CMD_MEASURE) begin
            xfer_is_meas = 1'b1;
            acks_ok      = 1'b1;
            reading_back = 1'b0;
            open_bus();
          end else begin
            busy     = 1'b0;
            consumed = 1'b1;
          end
        end
        PH_PWR_WAIT, PH_MEAS_WAIT, PH_SETTLE_WAIT: begin
          target = (bus_phase == PH_PWR_WAIT) ? cfg_pwr :
                   (bus_phase == PH_MEAS_WAIT) ? cfg_meas : cfg_settle;
          if (wait_ticks < target) begin
            wait_ticks = wait_ticks + 1'b1;
            consumed   = 1'b1;
          end else if (bus_phase == PH_PWR_WAIT) begin
            reading_back = 1'b0;
            open_bus();
          end else if (bus_phase == PH_MEAS_WAIT) begin
            reading_back = 1'b1;
            open_bus();
          end else begin
            bus_phase = PH_DONE;
          end
        end
        PH_START_A: begin
          bus_phase = PH_START_B;
          consumed  = 1'b1;
        end
        PH_START_B: begin
          sda_lo    = 1'b1;
          bus_phase = PH_WBIT_LO;
          consumed  = 1'b1;
        end
        PH_WBIT_LO, PH_WBIT_HI: begin
          hi       = (bus_phase == PH_WBIT_HI);
          scl_lo   = !hi;
          if (bit_idx < 8) sda_lo = !shreg[7 - bit_idx];
          consumed = 1'b1;
          if (!hi) begin
            bus_phase = PH_WBIT_HI;
          end else if (bit_idx < 8) begin
            bit_idx   = bit_idx + 1'b1;
            bus_phase = PH_WBIT_LO;
          end else begin
            // ninth bit: sensor ack sampled here
            if (sda) acks_ok = 1'b0;
            bit_idx = '0;
            if (reading_back) begin
              byte_idx  = '0;
              shreg     = '0;
              bus_phase = PH_RBIT_LO;
            end else begin
              byte_idx = byte_idx + 1'b1;
              if (byte_idx >= 4) begin
                bus_phase = PH_STOP_A;
              end else begin
                shreg     = out_byte(byte_idx);
                bus_phase = PH_WBIT_LO;
              end
            end
          end
        end
        PH_RBIT_LO, PH_RBIT_HI: begin
          hi     = (bus_phase == PH_RBIT_HI);
          scl_lo = !hi;
          // master ack on all but the last byte
          if (bit_idx >= 8) sda_lo = (int'(byte_idx) + 1 < RX_COUNT);
          consumed = 1'b1;
          if (!hi) begin
            bus_phase = PH_RBIT_HI;
          end else if (bit_idx < 8) begin
            shreg     = {shreg[6:0], sda};
            bit_idx   = bit_idx + 1'b1;
            bus_phase = PH_RBIT_LO;
          end else begin
            if (byte_idx < RX_COUNT) rx_bytes[byte_idx] = shreg;
            bit_idx   = '0;
            shreg     = '0;
            byte_idx  = byte_idx + 1'b1;
            bus_phase = (byte_idx >= RX_COUNT) ? PH_STOP_A : PH_RBIT_LO;
          end
        end
        PH_STOP_A: begin
          scl_lo    = 1'b1;
          sda_lo    = 1'b1;
          bus_phase = PH_STOP_B;
          consumed  = 1'b1;
        end
        PH_STOP_B: begin
          sda_lo    = 1'b1;
          bus_phase = PH_STOP_C;
          consumed  = 1'b1;
        end
        PH_STOP_C: begin
          consumed = 1'b1;
          if (reading_back) begin
            close_read();
            bus_phase = PH_DONE;
          end else if (!xfer_is_meas) begin
            wait_ticks = '0;
            bus_phase  = PH_SETTLE_WAIT;
          end else if (acks_ok) begin
            wait_ticks = '0;
            bus_phase  = PH_MEAS_WAIT;
          end else begin
            bus_phase = PH_DONE;   // write nack: no read phase
          end
        end
        PH_DONE: begin
          done      = 1'b1;
          ok        = acks_ok;
          bus_phase = PH_IDLE;
          consumed  = 1'b1;
        end
        default: begin
          bus_phase = PH_IDLE;
          busy      = 1'b0;
          consumed  = 1'b1;
        end
      endcase
    end
    w.scl_low  = scl_lo;
    w.sda_low  = sda_lo;
    w.busy     = busy;
    w.done     = done;
    w.success  = ok;
    w.hum_raw  = hum_store;
    w.temp_raw = temp_store;
    prod        = longint'(hum_store) * 10000;
    w.hum_centi = HUM_W'(prod >> 20);
    prod        = longint'(temp_store) * 20000;
    tc          = int'(prod >> 20) - 5000;
    w.temp_centi = tc[TEMP_W-1:0];
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_tick(input logic [1:0] cmd, input logic sda);
    expected_words.push_back(advance_bus(cmd, sda));
    tick_queue.push_back({5'b0, sda, cmd});
    ticks_made++;
  endtask

  // one command, every tick to its done word, up to three idle ticks; the sensor answers on SDA
  task automatic run_xfer(input logic [1:0] start_cmd, input sensor_mode_e mode);
    logic [7:0] resp [RX_COUNT];
    logic       sda;
    logic [1:0] cmd;
    int         n;
    @(negedge clk_i);
    foreach (resp[i]) resp[i] = 8'($urandom);
    if (mode == SENSOR_OK || mode == SENSOR_NACK) resp[0][STATUS_BUSY_BIT] = 1'b0;
    if (mode == SENSOR_BUSY) resp[0][STATUS_BUSY_BIT] = 1'b1;
    push_tick(start_cmd, 1'($urandom_range(1)));
    while (bus_phase != PH_IDLE) begin
      if (bus_phase == PH_WBIT_HI && bit_idx == 8) begin
        case (mode)
          SENSOR_NACK:  sda = ($urandom_range(3) == 0);
          SENSOR_NOISE: sda = 1'($urandom_range(1));
          default:      sda = 1'b0;
        endcase
      end else if (bus_phase == PH_RBIT_HI && bit_idx < 8) begin
        sda = (mode == SENSOR_NOISE) ? 1'($urandom_range(1)) : resp[byte_idx][7 - bit_idx];
      end else begin
        sda = 1'($urandom_range(1));
      end
      // commands offered mid-transaction must be ignored
      cmd = ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : CMD_TICK;
      push_tick(cmd, sda);
    end
    n = $urandom_range(3);
    repeat (n) push_tick($urandom_range(1) ? CMD_TICK : CMD_UNUSED, 1'($urandom_range(1)));
  endtask

  // block idle: all words back, then the pipeline latency
  task automatic settle_bus();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_DEV_ADDR:    cfg_addr   = val[ADDR_W-1:0];
      REG_POWER_UP:    cfg_pwr    = val;
      REG_INIT_SETTLE: cfg_settle = val;
      default:         cfg_meas   = val;
    endcase
  endtask

  task automatic set_timing(input logic [ADDR_W-1:0] addr, input logic [TICK_W-1:0] pwr,
                            input logic [TICK_W-1:0] settle, input logic [TICK_W-1:0] meas);
    settle_bus();
    write_reg(REG_DEV_ADDR, CFG_DATA_W'(addr));
    write_reg(REG_POWER_UP, pwr);
    write_reg(REG_INIT_SETTLE, settle);
    write_reg(REG_MEAS_WAIT, meas);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [TICK_W-1:0] pick_ticks();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return 20'd1;
    return TICK_W'($urandom_range(24, 2));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ADDR_W'($urandom_range(127));
  endfunction

  function automatic sensor_mode_e pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 55) return SENSOR_OK;
    if (r < 70) return SENSOR_NACK;
    if (r < 82) return SENSOR_BUSY;
    return SENSOR_NOISE;
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    int unsigned base;
    int          n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // idle words: plain ticks and the unused command, both SDA levels
    @(negedge clk_i);
    push_tick(CMD_TICK, 1'b0);
    push_tick(CMD_TICK, 1'b1);
    push_tick(CMD_UNUSED, 1'b0);
    push_tick(CMD_UNUSED, 1'b1);

    // reset address 0x38 with short waits
    settle_bus();
    write_reg(REG_POWER_UP, 20'd3);
    write_reg(REG_INIT_SETTLE, 20'd2);
    write_reg(REG_MEAS_WAIT, 20'd4);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    run_xfer(CMD_MEASURE, SENSOR_OK);

    // zero waits fall through within one tick; failure flavors
    set_timing('0, '0, '0, '0);
    run_xfer(CMD_INIT, SENSOR_OK);
    run_xfer(CMD_MEASURE, SENSOR_OK);
    run_xfer(CMD_MEASURE, SENSOR_BUSY);
    run_xfer(CMD_MEASURE, SENSOR_NACK);
    run_xfer(CMD_INIT, SENSOR_NACK);
    run_xfer(CMD_MEASURE, SENSOR_NOISE);

    // top address, longest init timing (unused by measure)
    set_timing('1, TICKS_MAX, TICKS_MAX, 20'd3);
    run_xfer(CMD_MEASURE, SENSOR_OK);
    run_xfer(CMD_MEASURE, SENSOR_OK);

    // longest measure wait, unused since only inits run
    set_timing(pick_addr(), 20'd2, 20'd1, TICKS_MAX);
    run_xfer(CMD_INIT, SENSOR_OK);
    run_xfer(CMD_INIT, SENSOR_NOISE);

    // random phases with short timing
    base = ticks_made;
    while (ticks_made - base < RANDOM_TICKS) begin
      set_timing(pick_addr(), pick_ticks(), pick_ticks(), pick_ticks());
      n = $urandom_range(3, 1);
      repeat (n) run_xfer($urandom_range(1) ? CMD_MEASURE : CMD_INIT, pick_mode());
    end

    settle_bus();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_humidity_sensor_i2c_reader: clean");
    end else begin
      $display("tb_humidity_sensor_i2c_reader: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: holds a word until taken, random gaps between words
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) tick_queue.delete(0);
      if (s_axis_tvalid && !s_axis_tready) begin
        // stalled: keep offering the same word
      end else if (tick_queue.size() != 0 &&
                   ((cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) ||
                    $urandom_range(99) >= 27)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tick_queue[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: random stalls plus one long hold-off to back up the block
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && cycle_cnt >= HOLD_AT && tick_queue.size() > 16) begin
      // start the hold-off only with words waiting, so the block backs up
      hold_left     <= HOLD_LEN;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) ||
                       ($urandom_range(99) >= 27);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted word against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (mismatches < 50) $display("mismatch at word %0d: %s", words_seen, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch($sformatf("%s got 'h%0h want 'h%0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        mon_want = expected_words.pop_front();
        mon_got  = bus_word_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
        check_field("scl_pull_low", mon_got.scl_low, mon_want.scl_low);
        check_field("sda_pull_low", mon_got.sda_low, mon_want.sda_low);
        check_field("busy", mon_got.busy, mon_want.busy);
        check_field("done", mon_got.done, mon_want.done);
        check_field("success", mon_got.success, mon_want.success);
        check_field("hum_raw", mon_got.hum_raw, mon_want.hum_raw);
        check_field("temp_raw", mon_got.temp_raw, mon_want.temp_raw);
        check_field("humidity_centi", mon_got.hum_centi, mon_want.hum_centi);
        check_field("temperature_centi", mon_got.temp_centi, mon_want.temp_centi);
        check_field("pad", m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W], 0);
      end
      words_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_humidity_sensor_i2c_reader: errors");
      $finish;
    end
  end

endmodule
